// ===== design/fpc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the firmware package checker.
// Depends on nothing; every other design file imports it.
package fpc_pkg;

  localparam int unsigned LIMIT_W = 25;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned HASH_W  = 64;

  localparam logic [LIMIT_W-1:0] MAX_IMAGE_BYTES = 25'd8388608;
  localparam logic [3:0]         MAX_DIGITS      = 4'd10;

  localparam logic [HASH_W-1:0]  FNV_BASIS     = 64'd14695981039346656037;
  localparam logic [SUM_W-1:0]   SUM_SEED      = 32'd171;
  localparam logic [7:0]         MAGIC_BYTE    = 8'he9;
  localparam logic [15:0]        CHIP_ID       = 16'd9;
  localparam logic [7:0]         MAX_SEGMENTS  = 8'd16;
  localparam logic [LIMIT_W-1:0] IMG_HDR_BYTES = 25'd24;
  localparam logic [LIMIT_W:0]   SIZE_SLACK    = 26'd12;

  localparam logic [7:0] CHAR_DASH  = 8'h2d;
  localparam logic [7:0] CHAR_TILDE = 8'h7e;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Byte positions of interest inside the image header.
  localparam logic [LIMIT_W-1:0] IDX_MAGIC    = 25'd0;
  localparam logic [LIMIT_W-1:0] IDX_SEGMENTS = 25'd1;
  localparam logic [LIMIT_W-1:0] IDX_CHIP_LO  = 25'd12;
  localparam logic [LIMIT_W-1:0] IDX_CHIP_HI  = 25'd13;
  localparam logic [LIMIT_W-1:0] IDX_HDR_LAST = 25'd23;

  // Parser phases.
  localparam logic [1:0] PH_DIGITS = 2'd0;
  localparam logic [1:0] PH_SEP    = 2'd1;
  localparam logic [1:0] PH_IMAGE  = 2'd2;
  localparam logic [1:0] PH_TAIL   = 2'd3;

  // Status codes.
  localparam logic [3:0] ST_OK           = 4'd0;
  localparam logic [3:0] ST_NO_CAPACITY  = 4'd1;
  localparam logic [3:0] ST_TOO_BIG      = 4'd2;
  localparam logic [3:0] ST_HDR_TRUNC    = 4'd3;
  localparam logic [3:0] ST_BAD_DIGIT    = 4'd4;
  localparam logic [3:0] ST_OVERFLOW     = 4'd5;
  localparam logic [3:0] ST_BAD_SEP      = 4'd6;
  localparam logic [3:0] ST_IMAGE_SHORT  = 4'd7;
  localparam logic [3:0] ST_IMAGE_BIG    = 4'd8;
  localparam logic [3:0] ST_SHORT_READ   = 4'd9;
  localparam logic [3:0] ST_BAD_MAGIC    = 4'd10;
  localparam logic [3:0] ST_WRONG_CHIP   = 4'd11;
  localparam logic [3:0] ST_BAD_SEGMENTS = 4'd12;
  localparam logic [3:0] ST_SIZE_CHANGED = 4'd13;
  localparam logic [3:0] ST_CSUM_BAD     = 4'd14;
  localparam logic [3:0] ST_NONE         = 4'd15;

  typedef struct packed {
    logic [7:0]         data_byte;
    logic               has_byte;
    logic               last;
    logic [LIMIT_W-1:0] file_size;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         status;
    logic [SUM_W-1:0]   expected_checksum;
    logic [SUM_W-1:0]   computed_checksum;
    logic [HASH_W-1:0]  fingerprint;
    logic [3:0]         payload_offset;
    logic [LIMIT_W-1:0] image_size;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } core_result_t;

endpackage

// ===== design/fpc_digest.sv =====
`timescale 1ns / 1ps
// Per-byte update of the additive checksum and the 64-bit FNV-1a hash.
// Depends on fpc_pkg.
module fpc_digest
  import fpc_pkg::*;
(
  input  logic [7:0]        data_byte,
  input  logic [SUM_W-1:0]  sum_cur,
  input  logic [HASH_W-1:0] hash_cur,
  output logic [SUM_W-1:0]  sum_nxt,
  output logic [HASH_W-1:0] hash_nxt
);

  logic [HASH_W-1:0] mixed;

  // The FNV prime is 2^40 + 0x1b3, so the multiply is a handful of shifted adds.
  assign mixed    = hash_cur ^ {56'd0, data_byte};
  assign hash_nxt = (mixed << 40) + (mixed << 8) + (mixed << 7) + (mixed << 5)
                  + (mixed << 4) + (mixed << 1) + mixed;
  assign sum_nxt  = sum_cur + {24'd0, data_byte};

endmodule

// ===== design/fpc_core.sv =====
`timescale 1ns / 1ps
// Parser state and per-word decision logic of the package checker.
// Depends on fpc_pkg and fpc_digest.
module fpc_core
  import fpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  in_item_t           item,
  input  logic [LIMIT_W-1:0] image_limit,
  output core_result_t       result
);

  logic [1:0]         phase_r, phase_nxt;
  logic [3:0]         dcount_r, dcount_nxt;
  logic [SUM_W-1:0]   exp_sum_r, exp_sum_nxt;
  logic [3:0]         hlen_r, hlen_nxt;
  logic [LIMIT_W-1:0] icount_r, icount_nxt;
  logic [SUM_W-1:0]   run_sum_r, run_sum_nxt;
  logic [HASH_W-1:0]  hash_r, hash_nxt;
  logic [7:0]         chip_lo_r, chip_lo_nxt;
  logic [7:0]         chip_hi_r, chip_hi_nxt;
  logic [7:0]         magic_r, magic_nxt;
  logic [7:0]         seg_r, seg_nxt;
  logic               fault_r, fault_nxt;
  logic [LIMIT_W-1:0] decl_r, decl_nxt;
  logic [LIMIT_W-1:0] img_r, img_nxt;

  logic [SUM_W-1:0]   dig_sum;
  logic [HASH_W-1:0]  dig_hash;
  logic [LIMIT_W-1:0] clamped;
  logic [35:0]        scaled;
  logic [3:0]         digit;
  logic [3:0]         hlen_inc;
  logic [LIMIT_W-1:0] img_diff;
  logic [3:0]         st;
  logic               restart;

  fpc_digest u_digest (
    .data_byte (item.data_byte),
    .sum_cur   (run_sum_r),
    .hash_cur  (hash_r),
    .sum_nxt   (dig_sum),
    .hash_nxt  (dig_hash)
  );

  assign clamped  = (image_limit > MAX_IMAGE_BYTES) ? MAX_IMAGE_BYTES : image_limit;
  assign digit    = 4'(item.data_byte - CHAR_ZERO);
  assign scaled   = ({4'd0, exp_sum_r} << 3) + ({4'd0, exp_sum_r} << 1) + {32'd0, digit};
  assign hlen_inc = hlen_r + 4'd1;
  assign img_diff = decl_r - {21'd0, hlen_inc};

  always_comb begin
    phase_nxt   = phase_r;
    dcount_nxt  = dcount_r;
    exp_sum_nxt = exp_sum_r;
    hlen_nxt    = hlen_r;
    icount_nxt  = icount_r;
    run_sum_nxt = run_sum_r;
    hash_nxt    = hash_r;
    chip_lo_nxt = chip_lo_r;
    chip_hi_nxt = chip_hi_r;
    magic_nxt   = magic_r;
    seg_nxt     = seg_r;
    fault_nxt   = fault_r;
    decl_nxt    = decl_r;
    img_nxt     = img_r;
    st          = ST_NONE;
    restart     = 1'b0;

    if (fault_r) begin
      restart = item.last;
    end else begin
      // Size checks run until the first byte has been taken.
      if (phase_r == PH_DIGITS && hlen_r == 4'd0) begin
        if (image_limit == '0) begin
          st = ST_NO_CAPACITY;
        end else if ({1'b0, item.file_size} > ({1'b0, clamped} + SIZE_SLACK)) begin
          st = ST_TOO_BIG;
        end else if (item.has_byte) begin
          decl_nxt = item.file_size;
        end
      end

      if (st == ST_NONE && item.has_byte) begin
        unique case (phase_r)
          PH_DIGITS: begin
            hlen_nxt = hlen_inc;
            if (item.data_byte == CHAR_DASH) begin
              if (dcount_r == 4'd0) begin
                st = ST_BAD_SEP;
              end else begin
                phase_nxt = PH_SEP;
              end
            end else if (item.data_byte < CHAR_ZERO || item.data_byte > CHAR_NINE ||
                         dcount_r >= MAX_DIGITS) begin
              st = ST_BAD_DIGIT;
            end else begin
              dcount_nxt = dcount_r + 4'd1;
              if (scaled[35:32] != 4'd0) begin
                st = ST_OVERFLOW;
              end else begin
                exp_sum_nxt = scaled[31:0];
              end
            end
          end
          PH_SEP: begin
            hlen_nxt = hlen_inc;
            if (item.data_byte != CHAR_TILDE) begin
              st = ST_BAD_SEP;
            end else if (decl_r < {21'd0, hlen_inc} || img_diff < IMG_HDR_BYTES) begin
              st = ST_IMAGE_SHORT;
            end else begin
              img_nxt = img_diff;
              if (img_diff > clamped) begin
                st = ST_IMAGE_BIG;
              end else begin
                phase_nxt = PH_IMAGE;
              end
            end
          end
          PH_IMAGE: begin
            if (icount_r == IDX_MAGIC)    magic_nxt   = item.data_byte;
            if (icount_r == IDX_SEGMENTS) seg_nxt     = item.data_byte;
            if (icount_r == IDX_CHIP_LO)  chip_lo_nxt = item.data_byte;
            if (icount_r == IDX_CHIP_HI)  chip_hi_nxt = item.data_byte;
            run_sum_nxt = dig_sum;
            hash_nxt    = dig_hash;
            icount_nxt  = icount_r + 25'd1;
            // The checked header fields are already captured when the last header byte arrives.
            if (icount_r == IDX_HDR_LAST) begin
              if (magic_r != MAGIC_BYTE) begin
                st = ST_BAD_MAGIC;
              end else if ({chip_hi_r, chip_lo_r} != CHIP_ID) begin
                st = ST_WRONG_CHIP;
              end else if (seg_r == 8'd0 || seg_r > MAX_SEGMENTS) begin
                st = ST_BAD_SEGMENTS;
              end
            end
            if (icount_nxt >= img_r) begin
              phase_nxt = PH_TAIL;
            end
          end
          PH_TAIL: begin
            st = ST_SIZE_CHANGED;
          end
          default: begin
            st = ST_NONE;
          end
        endcase
      end

      if (st == ST_NONE && item.last) begin
        unique case (phase_nxt)
          PH_DIGITS: st = ST_HDR_TRUNC;
          PH_SEP:    st = ST_BAD_SEP;
          PH_IMAGE:  st = ST_SHORT_READ;
          PH_TAIL: begin
            if (item.file_size != decl_nxt) begin
              st = ST_SIZE_CHANGED;
            end else if (run_sum_nxt != exp_sum_nxt) begin
              st = ST_CSUM_BAD;
            end else begin
              st = ST_OK;
            end
          end
          default: st = ST_NONE;
        endcase
      end

      if (st != ST_NONE) begin
        if (item.last) begin
          restart = 1'b1;
        end else begin
          fault_nxt = 1'b1;
        end
      end
    end

    result.valid                  = !fault_r && st != ST_NONE;
    result.item.status            = st;
    result.item.expected_checksum = exp_sum_nxt;
    result.item.computed_checksum = run_sum_nxt;
    result.item.fingerprint       = hash_nxt;
    result.item.payload_offset    = hlen_nxt;
    result.item.image_size        = (st == ST_IMAGE_SHORT) ? '0 : img_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && restart)) begin
      phase_r   <= PH_DIGITS;
      dcount_r  <= '0;
      exp_sum_r <= '0;
      hlen_r    <= '0;
      icount_r  <= '0;
      run_sum_r <= SUM_SEED;
      hash_r    <= FNV_BASIS;
      chip_lo_r <= '0;
      chip_hi_r <= '0;
      magic_r   <= '0;
      seg_r     <= '0;
      fault_r   <= 1'b0;
      decl_r    <= '0;
      img_r     <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      dcount_r  <= dcount_nxt;
      exp_sum_r <= exp_sum_nxt;
      hlen_r    <= hlen_nxt;
      icount_r  <= icount_nxt;
      run_sum_r <= run_sum_nxt;
      hash_r    <= hash_nxt;
      chip_lo_r <= chip_lo_nxt;
      chip_hi_r <= chip_hi_nxt;
      magic_r   <= magic_nxt;
      seg_r     <= seg_nxt;
      fault_r   <= fault_nxt;
      decl_r    <= decl_nxt;
      img_r     <= img_nxt;
    end
  end

endmodule

// ===== design/firmware_package_checker.sv =====
`timescale 1ns / 1ps
// Top level of the firmware package checker: input register, result register,
// capacity register and the parser core. Depends on fpc_pkg and fpc_core.
//
//   Port group   Direction   Handshake              Word
//   in_*         input       in_valid / in_ready    in_item (in_item_t)
//   out_*        output      out_valid / out_ready  out_item (out_item_t)
//   cfg_*        input       cfg_valid / cfg_ready  cfg_image_limit, 25 bits
//
// Each accepted word sits in the input register while the core processes it; a
// result, if any, is loaded into the result register when the core steps the
// word, so out_valid rises the cycle after that step. Sustained throughput is
// one word per clock while a waiting result does not stall the step, set by the
// combinational update of the parser state (the FNV multiply is a constant shift-and-add).
// Reset (rst_n, synchronous, active low) empties both registers, clears the
// capacity to zero and restarts the parser. When a result waits and out_ready
// is low, the input register still drains words that produce no result; a word
// that does produce one waits in the input register, and in_ready drops.
module firmware_package_checker
  import fpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_image_limit
);

  logic               in_vld_r;
  in_item_t           in_item_r;
  logic               out_vld_r;
  out_item_t          out_item_r;
  logic [LIMIT_W-1:0] limit_r;
  core_result_t       core_res;
  logic               step;

  // The held word may be processed unless it yields a result and the result
  // register is still occupied by one that has not been taken.
  assign step     = in_vld_r && (!core_res.valid || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || step;
  assign cfg_ready = 1'b1;

  fpc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .item        (in_item_r),
    .image_limit (limit_r),
    .result      (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      limit_r   <= '0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (step && core_res.valid) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_valid) begin
        limit_r <= cfg_image_limit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_item;
    end
    if (step && core_res.valid) begin
      out_item_r <= core_res.item;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule
